// ----- sv/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the bicolour frame buffer
// Panel geometry, bus byte constants, operation codes and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

   localparam int DISPLAY_WIDTH  = 16;
   localparam int DISPLAY_HEIGHT = 8;
   localparam int COL_W          = $clog2(DISPLAY_WIDTH);
   localparam int ROW_W          = $clog2(DISPLAY_HEIGHT);

   localparam logic [7:0] BRIGHT_BASE   = 8'hE0;
   localparam logic [3:0] BRIGHT_MAX    = 4'd15;
   localparam logic [7:0] POSITION_BYTE = 8'h00;
   localparam logic [6:0] LEFT_ADDR_RST  = 7'h70;
   localparam logic [6:0] RIGHT_ADDR_RST = 7'h71;

   // byte index within one panel transfer: position byte, then 8 pairs
   localparam int              IDX_W    = 5;
   localparam logic [IDX_W-1:0] IDX_LAST = 5'd16;

   typedef enum logic [1:0] {
      OP_PIXEL  = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_BRIGHT = 2'd3
   } op_type;

   typedef enum logic {
      REG_LEFT_ADDR  = 1'b0,
      REG_RIGHT_ADDR = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic             apply;  // request accepted this cycle
      op_type           op;     // its operation
      logic             push;   // load next bus byte into output register
      logic             flush;  // current burst is a flush (else brightness)
      logic             panel;  // second transfer of the burst
      logic [IDX_W-1:0] idx;    // byte within the transfer
   } fbc_cmd_type;

   typedef struct packed {
      logic slot_free;          // output register can take a byte
   } fbc_sts_type;

endpackage

`default_nettype wire

// ----- sv/fbc_if.sv -----
// ----------------------------------------------------------------------------
// fbc_if: request and response channels of the bicolour frame buffer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbc_req_if
   import fbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   op_type            cmd;
   logic signed [7:0] pos_x;
   logic signed [7:0] pos_y;
   logic [1:0]        colour;
   logic [7:0]        level;

   modport source (output valid, cmd, pos_x, pos_y, colour, level, input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, colour, level, output ready);
endinterface

interface fbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] device;
   logic       starts_transfer;
   logic [7:0] data_byte;
   logic       ends_transfer;
   logic       last;

   modport source (output valid, device, starts_transfer, data_byte, ends_transfer,
                   last, input ready);
   modport sink   (input valid, device, starts_transfer, data_byte, ends_transfer,
                   last, output ready);
endinterface

`default_nettype wire

// ----- sv/bicolor_matrix_framebuffer_core.sv -----
// ----------------------------------------------------------------------------
// bicolor_matrix_framebuffer_core: 16x8 two-colour LED frame buffer
// Keeps red and green planes and turns flush and brightness requests into
// bus bytes for the left and right 8x8 panel controllers.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one request: pixel draw, clear, flush or brightness.
//    req.ready is high while no burst is being emitted.
//  - Pixel and clear requests take effect at the accepting edge and give no
//    response; the next request is taken in the following cycle.
//  - Flush gives 34 response bytes (right panel transfer, then left), a
//    brightness request 2 (left, then right). After acceptance the sequencer
//    enters its emit state and loads the first byte into the output
//    register; after that one byte per cycle while rsp.ready stays high.
//    A burst holds the request side until its final byte is loaded.
//  - rsp.last marks the final byte of a burst.
//  - A stalled receiver holds the byte in the output register and the
//    sequencer waits; no byte is lost or repeated.
//  - csr_we/csr_index/csr_wdata write the two panel addresses (index 0 left,
//    index 1 right); write only while no burst is in progress.
//  - Synchronous reset clears both planes, sets the addresses to 0x70 and
//    0x71 and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bicolor_matrix_framebuffer_core
   import fbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   fbc_req_if.sink         req,
   fbc_rsp_if.source       rsp,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata
);

   fbc_cmd_type cmd;      // sequencer to datapath
   fbc_sts_type sts;      // datapath to sequencer
   logic        req_ready;

   assign req.ready = req_ready;

   // request sequencer: idle/emit control and byte counter
   fbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // planes, panel addresses, byte builder and output register
   fbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .pos_x     (req.pos_x),
      .pos_y     (req.pos_y),
      .colour    (req.colour),
      .level     (req.level),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ----- sv/fbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbc_ctrl: request sequencer
// Takes requests while idle and steps through the bytes of a flush or
// brightness burst, one per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_ctrl
   import fbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire op_type      req_cmd,
   output logic             req_ready,
   output fbc_cmd_type      cmd,
   input  wire fbc_sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic             flush_ff, flush_in;
   logic             panel_ff, panel_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             push;
   logic             last_byte;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign push      = (state_ff == ST_EMIT) && sts.slot_free;
   assign last_byte = panel_ff && (!flush_ff || idx_ff == IDX_LAST);

   always_comb begin
      state_in = state_ff;
      flush_in = flush_ff;
      panel_in = panel_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == OP_FLUSH || req_cmd == OP_BRIGHT)) begin
               state_in = ST_EMIT;
               flush_in = (req_cmd == OP_FLUSH);
               panel_in = 1'b0;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (push) begin
               if (last_byte) begin
                  state_in = ST_IDLE;
               end else if (!flush_ff || idx_ff == IDX_LAST) begin
                  panel_in = 1'b1;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
         panel_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
         panel_ff <= panel_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      cmd.apply = accept;
      cmd.op    = req_cmd;
      cmd.push  = push;
      cmd.flush = flush_ff;
      cmd.panel = panel_ff;
      cmd.idx   = idx_ff;
   end

   // a burst request always leads into the emit state
   a_burst_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == OP_FLUSH || req_cmd == OP_BRIGHT) |=> state_ff == ST_EMIT)
      else $error("burst request did not start emitting");

   // final byte of a burst returns to idle
   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      push && last_byte |=> state_ff == ST_IDLE)
      else $error("burst did not end after final byte");

   // byte index stays within a transfer; brightness never goes past its first byte
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff <= IDX_LAST && (flush_ff || idx_ff == '0))
      else $error("byte index out of range");

endmodule

`default_nettype wire

// ----- sv/fbc_datapath.sv -----
// ----------------------------------------------------------------------------
// fbc_datapath: frame planes, address registers and output register
// Applies pixel and clear requests, builds column bytes for a flush and
// the brightness byte, and holds the response until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_datapath
   import fbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fbc_cmd_type       cmd,
   output fbc_sts_type            sts,
   input  wire logic signed [7:0] pos_x,
   input  wire logic signed [7:0] pos_y,
   input  wire logic [1:0]        colour,
   input  wire logic [7:0]        level,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [6:0]        csr_wdata,
   fbc_rsp_if.source              rsp
);

   logic [DISPLAY_WIDTH-1:0] red_ff   [DISPLAY_HEIGHT];
   logic [DISPLAY_WIDTH-1:0] red_in   [DISPLAY_HEIGHT];
   logic [DISPLAY_WIDTH-1:0] green_ff [DISPLAY_HEIGHT];
   logic [DISPLAY_WIDTH-1:0] green_in [DISPLAY_HEIGHT];
   logic [6:0]               left_addr_ff;
   logic [6:0]               right_addr_ff;
   logic [3:0]               level_ff;

   logic                     in_range;
   logic [COL_W-1:0]         pix_bit;
   logic [ROW_W-1:0]         pix_row;

   logic [IDX_W-1:0]         pair_pos;
   logic [COL_W-1:0]         col_bit;
   logic [7:0]               col_green;
   logic [7:0]               col_red;
   logic                     to_right;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [6:0]               device_ff;
   logic                     starts_ff;
   logic [7:0]               data_ff;
   logic                     ends_ff;
   logic                     last_ff;
   logic [7:0]               data_in;

   // pixel decode: negative coordinates have the sign bit set
   assign in_range = !pos_x[7] && (pos_x < 8'(DISPLAY_WIDTH))
                     && !pos_y[7] && (pos_y < 8'(DISPLAY_HEIGHT));
   assign pix_bit  = COL_W'(DISPLAY_WIDTH - 1) - pos_x[COL_W-1:0];
   assign pix_row  = pos_y[ROW_W-1:0];

   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      if (cmd.apply) begin
         case (cmd.op)
            OP_PIXEL: begin
               if (in_range) begin
                  red_in[pix_row][pix_bit]   = colour[0];
                  green_in[pix_row][pix_bit] = colour[1];
               end
            end
            OP_CLEAR: begin
               for (int r = 0; r < DISPLAY_HEIGHT; r++) begin
                  red_in[r]   = '0;
                  green_in[r] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DISPLAY_HEIGHT; r++) begin
            red_ff[r]   <= '0;
            green_ff[r] <= '0;
         end
         left_addr_ff  <= LEFT_ADDR_RST;
         right_addr_ff <= RIGHT_ADDR_RST;
      end else begin
         red_ff   <= red_in;
         green_ff <= green_in;
         if (csr_we && csr_index == REG_LEFT_ADDR) begin
            left_addr_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_RIGHT_ADDR) begin
            right_addr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && cmd.op == OP_BRIGHT) begin
         level_ff <= (level > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : level[3:0];
      end
   end

   // byte idx 1..16 is pair (idx-1)/2, green first; second transfer uses high half
   assign pair_pos = cmd.idx - 1'b1;
   assign col_bit  = {cmd.panel, pair_pos[COL_W-1:1]};

   always_comb begin
      for (int r = 0; r < DISPLAY_HEIGHT; r++) begin
         col_green[r] = green_ff[r][col_bit];
         col_red[r]   = red_ff[r][col_bit];
      end
   end

   // flush goes right then left, brightness left then right
   assign to_right = cmd.flush ^ cmd.panel;

   always_comb begin
      if (!cmd.flush) begin
         data_in = BRIGHT_BASE | {4'd0, level_ff};
      end else if (cmd.idx == '0) begin
         data_in = POSITION_BYTE;
      end else if (pair_pos[0]) begin
         data_in = col_red;
      end else begin
         data_in = col_green;
      end
   end

   assign sts.slot_free = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in  = cmd.push ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         device_ff <= to_right ? right_addr_ff : left_addr_ff;
         starts_ff <= !cmd.flush || cmd.idx == '0;
         data_ff   <= data_in;
         ends_ff   <= !cmd.flush || cmd.idx == IDX_LAST;
         last_ff   <= cmd.panel && (!cmd.flush || cmd.idx == IDX_LAST);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.device          = device_ff;
   assign rsp.starts_transfer = starts_ff;
   assign rsp.data_byte       = data_ff;
   assign rsp.ends_transfer   = ends_ff;
   assign rsp.last            = last_ff;

   // a byte is only loaded into a free output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.push && rsp_valid_ff |-> rsp.ready)
      else $error("response overwritten before being taken");

   // the last byte of a burst always closes a transfer
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> ends_ff)
      else $error("final byte does not end a transfer");

   // a stalled response stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(data_ff) && $stable(device_ff))
      else $error("response changed while stalled");

endmodule

`default_nettype wire
